FILE: hdl/btte_pkg.sv
// shared types and constants for the byte to ternary text encoder
// no dependencies; imported by every module of the block
package btte_pkg;

    localparam int MAX_DIGITS = 6;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    typedef logic [7:0] t_char;

    localparam t_char SEP_CHAR  = 8'h7C;
    localparam t_char NEG_CHAR  = 8'h54;
    localparam t_char ZERO_CHAR = 8'h30;

    // floor(n / 3) = (n * 171) >> 9 for every n below 256
    localparam logic [8:0] DIV3_MUL   = 9'd171;
    localparam int         DIV3_SHIFT = 9;

    // digit characters of one byte, least significant digit in slot 0
    typedef struct packed {
        logic [MAX_DIGITS-1:0][7:0] chars;
        logic [CNT_W-1:0]           cnt;
    } t_entry;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } t_front_state;

endpackage

FILE: hdl/byte_to_ternary_text_encoder.sv
// Byte to ternary text encoder. Each accepted byte leaves as its base-3 digits in ASCII,
// most significant first, with no leading zeros (zero gives a single '0'), followed by
// a '|' word flagged with tlast. The balanced_mode register selects digits '0','1','2'
// or balanced digits 'T','0','1'; write it only while the block is idle. A byte has 1 to
// 6 digits. The front end takes the byte, runs one divide-by-three step per digit and
// then hands the digits to a two-entry queue, waiting while the queue is full. The back
// end takes them from the queue, then sends one character word per cycle while the
// receiver is ready, digits and separator, through its output register. The queue lets
// a new byte be converted while earlier ones are still being sent.
// depends on btte_pkg, btte_front, btte_queue, btte_back
module byte_to_ternary_text_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,     // balanced_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // last_of_run
);
    import btte_pkg::*;

    logic   r_balanced;
    logic   w_push;
    logic   w_q_ready;
    t_entry w_front_entry;
    logic   w_q_valid;
    logic   w_pop;
    t_entry w_q_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balanced <= 1'b0;
        end else if (i_cfg_valid) begin
            r_balanced <= i_cfg_data;
        end
    end

    btte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_balanced    (r_balanced),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .o_push        (w_push),
        .i_queue_ready (w_q_ready),
        .o_entry       (w_front_entry)
    );

    btte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_entry (w_front_entry),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_q_entry)
    );

    btte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .i_entry (w_q_entry),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

FILE: hdl/btte_front.sv
// front end: accepts a byte and produces its digit characters, one per cycle
// depends on btte_pkg; feeds btte_queue
module btte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_balanced,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    input  logic              i_queue_ready,
    output btte_pkg::t_entry  o_entry
);
    import btte_pkg::*;

    t_front_state r_state, n_state;
    logic [7:0]   r_n, n_n;
    t_entry       r_entry, n_entry;

    logic [16:0]  w_prod;
    logic [7:0]   w_quot;
    logic [7:0]   w_rem_full;
    logic [1:0]   w_rem;
    logic [7:0]   w_next_n;
    t_char        w_char;

    // one digit: reciprocal multiply and correction
    assign w_prod     = {1'b0, r_n} * DIV3_MUL;
    assign w_quot     = w_prod[DIV3_SHIFT +: 8];
    assign w_rem_full = r_n - {w_quot[6:0], 1'b0} - w_quot;
    assign w_rem      = w_rem_full[1:0];

    always_comb begin
        if (i_balanced && w_rem == 2'd2) begin
            w_char   = NEG_CHAR;
            w_next_n = w_quot + 8'd1;
        end else begin
            w_char   = ZERO_CHAR + {6'd0, w_rem};
            w_next_n = w_quot;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_valid) n_state = FS_CONV;
            end
            FS_CONV: begin
                if (w_next_n == 8'd0) n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (i_queue_ready) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        n_n     = r_n;
        n_entry = r_entry;
        case (r_state)
            FS_IDLE: begin
                o_ready     = 1'b1;
                n_n         = i_byte;
                n_entry.cnt = '0;
            end
            FS_CONV: begin
                // a zero byte falls out of the same step as the single digit '0'
                n_entry.chars[r_entry.cnt] = w_char;
                n_entry.cnt                = r_entry.cnt + CNT_W'(1);
                n_n                        = w_next_n;
            end
            FS_PUSH: begin
                o_push = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n     <= n_n;
        r_entry <= n_entry;
    end

endmodule

FILE: hdl/btte_queue.sv
// two-entry queue of converted bytes between front and back ends
// depends on btte_pkg
module btte_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_ready,
    input  btte_pkg::t_entry  i_entry,
    output logic              o_valid,
    input  logic              i_pop,
    output btte_pkg::t_entry  o_entry
);
    import btte_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (w_rd) r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            if (w_wr && !w_rd) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
        if (w_wr) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

FILE: hdl/btte_back.sv
// back end: sends digit characters most significant first, then the separator
// depends on btte_pkg; drains btte_queue into the output register
module btte_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_pop,
    input  btte_pkg::t_entry  i_entry,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_char,
    output logic              o_last
);
    import btte_pkg::*;

    logic                      r_busy;
    logic [MAX_DIGITS-1:0][7:0] r_chars;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_valid;
    t_char                     r_char;
    logic                      r_last;
    logic                      w_free;
    logic [CNT_W-1:0]          w_idx_m1;

    assign w_free   = !r_valid || i_ready;
    assign o_pop    = !r_busy && i_valid;
    assign w_idx_m1 = r_idx - CNT_W'(1);

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_free && r_idx == '0) begin
                r_busy <= 1'b0;
            end
            if (r_busy && w_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_chars <= i_entry.chars;
            r_idx   <= i_entry.cnt;
        end else if (r_busy && w_free) begin
            if (r_idx != '0) begin
                r_char <= r_chars[w_idx_m1];
                r_last <= 1'b0;
                r_idx  <= w_idx_m1;
            end else begin
                r_char <= SEP_CHAR;
                r_last <= 1'b1;
            end
        end
    end

endmodule

FILE: dv/btte_text_checker.sv
// checker for the byte to ternary text encoder: tracks the mode register, predicts the
// character words of every accepted byte and compares them with the output stream
// depends on btte_pkg
`timescale 1ns / 1ps

module btte_text_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_open_words
);
    import btte_pkg::*;

    localparam logic [8:0] RADIX      = 9'd3;
    localparam logic [1:0] NEG_REMAIN = 2'd2;
    localparam int         SHOW_LIMIT = 10;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_word;

    t_text_word pending_chars[$];
    logic       balanced_copy;
    int         mismatches;

    // digits come out least significant first, so build the run from the front
    function automatic void expand_to_ternary(input logic [7:0] value, input logic balanced);
        t_char      digits[$];
        logic [8:0] n;
        logic [1:0] r;
        t_text_word w;
        n = {1'b0, value};
        if (n == 0) begin
            digits.push_front(ZERO_CHAR);
        end
        while (n != 0) begin
            r = 2'(n % RADIX);
            if (balanced && r == NEG_REMAIN) begin
                digits.push_front(NEG_CHAR);
                n = n + 9'd1;
            end else begin
                digits.push_front(t_char'(ZERO_CHAR + r));
            end
            n = n / RADIX;
        end
        foreach (digits[i]) begin
            w.ch   = digits[i];
            w.last = 1'b0;
            pending_chars = {pending_chars, w};
        end
        w.ch   = SEP_CHAR;
        w.last = 1'b1;
        pending_chars = {pending_chars, w};
    endfunction

    always @(posedge i_clk) begin
        t_text_word want;
        if (!i_rst_n) begin
            balanced_copy = 1'b0;
            pending_chars.delete();
        end else begin
            // output side first: a word in the same cycle cannot belong to this byte
            if (i_out_valid && i_out_ready) begin
                if (pending_chars.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("%0t: unexpected word char %h last %b",
                                 $realtime, i_out_char, i_out_last);
                    end
                end else begin
                    want = pending_chars.pop_front();
                    if (want.ch !== i_out_char || want.last !== i_out_last) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display({"%0t: word mismatch, expected char %h last %b,",
                                      " got char %h last %b"},
                                     $realtime, want.ch, want.last,
                                     i_out_char, i_out_last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expand_to_ternary(i_in_byte, balanced_copy);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                balanced_copy = i_cfg_data;
            end
        end
        o_open_words <= pending_chars.size();
        o_fail_count <= mismatches;
    end

    initial begin
        mismatches    = 0;
        balanced_copy = 1'b0;
        o_fail_count  = 0;
        o_open_words  = 0;
    end

endmodule

FILE: dv/tb_byte_to_ternary_text_encoder.sv
// testbench top for the byte to ternary text encoder: clock, reset, byte and mode stimulus
// with random idling and back-pressure; checking is done by btte_text_checker
`timescale 1ns / 1ps

module tb_byte_to_ternary_text_encoder;

    import btte_pkg::*;

    localparam int N_DIRECTED  = 12;
    localparam int N_EDGE      = 10;
    localparam int PHASE_BYTES = 62;
    localparam int BURST_BYTES = 24;
    localparam int HOLD_CYCLES = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int fail_count;
    int open_words;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int stall_left   = 0;

    // zero, one and two digits, longest runs, balanced carries, alternating bits
    logic [7:0] directed_bytes [N_DIRECTED] =
        '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd121, 8'd122, 8'd242, 8'd243, 8'd255, 8'd170, 8'd85};
    logic [7:0] edge_bytes [N_EDGE] =
        '{8'd0, 8'd1, 8'd2, 8'd80, 8'd81, 8'd121, 8'd122, 8'd242, 8'd243, 8'd255};

    byte_to_ternary_text_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    btte_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_char   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_open_words (open_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left    = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_byte();
        if ($urandom_range(99) < 15) begin
            send_byte(edge_bytes[$urandom_range(N_EDGE - 1)]);
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // stop offering and wait until every predicted word has left the block
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_words != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic balanced);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= balanced;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        write_mode(1'b1);
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        for (int phase = 0; phase < 6; phase++) begin
            write_mode(phase[0]);
            case (phase / 2)
                0: begin
                    src_idle_pct = 10;
                    snk_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_idle_pct = 10;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            // keep offering bytes while the receiver is held off so the input backs up
            if (phase == 4) begin
                hold_req = hold_req + 1;
                repeat (BURST_BYTES) send_random_byte();
            end
            for (int k = 0; k < PHASE_BYTES; k++) begin
                if (phase == 2 && k == PHASE_BYTES / 2) begin
                    wait_for_drain();
                end
                send_random_byte();
            end
        end

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && open_words == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
